// File: rtl/core/sqbs_pkg.sv
// Shared types, constants and the quarter-wave sine table for sprite quad setup.
// Depends on nothing; every other file of the block imports it.
package sqbs_pkg;

	localparam int QUAD_LIMIT      = 16384;
	localparam int SLOT_TABLE_SIZE = 32;
	localparam int SINE_ENTRIES    = 1024;
	localparam int QDEPTH          = 2;

	localparam int CNT_W  = $clog2(SLOT_TABLE_SIZE + 1);
	localparam int SIDX_W = $clog2(SLOT_TABLE_SIZE);
	localparam int SIN_W  = $clog2(SINE_ENTRIES + 1);
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] CMD_DRAW  = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	typedef logic [15:0] sine_tab_t [0:SINE_ENTRIES];

	typedef struct packed {
		logic        is_end;
		logic        pre_flush;
		logic [14:0] fcount;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] size_x;
		logic [31:0] size_y;
		logic [15:0] angle;
		logic [4:0]  slot;
		logic [15:0] tiling;
		logic [31:0] color;
	} sqbs_job_t;

	// Taylor series in Q30, rounded to Q14 and clamped at one.
	function automatic sine_tab_t build_sine();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int i = 0; i <= SINE_ENTRIES; i++) begin
			x  = (64'(i) * HALF_PI_Q30) / SINE_ENTRIES;
			x2 = (x * x) >> 30;
			t  = ONE_Q30 - x2 / 72;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
			s  = (x * t) >> 30;
			s  = (s + 64'd32768) >> 16;
			if (s > 64'd16384)
				s = 64'd16384;
			tab[i] = s[15:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// File: rtl/core/sqbs_front.sv
// Command front end: takes requests, looks up texture slots, decides flushes.
// Depends on sqbs_pkg; pushes jobs into the queue in front of sqbs_back.
module sqbs_front import sqbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] size_x,
	input  logic [31:0] size_y,
	input  logic [15:0] angle,
	input  logic [15:0] texture_id,
	input  logic [15:0] tiling,
	input  logic [31:0] color,
	output logic        push,
	output sqbs_job_t   push_job,
	input  logic        q_full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CMP  = 2'd1;
	localparam logic [1:0] F_DEC  = 2'd2;

	logic [1:0]        state_q;
	logic [1:0]        cmd_q;
	logic [31:0]       pos_x_q, pos_y_q, pos_z_q, size_x_q, size_y_q, color_q;
	logic [15:0]       angle_q, tid_q, tiling_q;
	logic [15:0]       slot_ids_q [1:SLOT_TABLE_SIZE-1];
	logic [SLOT_TABLE_SIZE-1:1] match_q;
	logic [CNT_W-1:0]  slot_count_q;
	logic [14:0]       batch_q;

	logic              tex, found, need_flush, dec_go;
	logic [SIDX_W-1:0] enc;
	logic [CNT_W-1:0]  cnt_base;
	logic [14:0]       batch_base;
	logic [CNT_W-1:0]  slot_sel;

	assign cmd_stall = (state_q != F_IDLE);

	always_comb begin
		enc = '0;
		for (int i = SLOT_TABLE_SIZE - 1; i >= 1; i--)
			if (match_q[i])
				enc = SIDX_W'(i);
	end

	assign tex        = (tid_q != 16'd0);
	assign need_flush = (32'(batch_q) >= 32'(QUAD_LIMIT)) ||
		(tex && !(|match_q) && (32'(slot_count_q) >= 32'(SLOT_TABLE_SIZE)));
	assign found      = tex && (|match_q) && !need_flush;
	assign cnt_base   = need_flush ? CNT_W'(1) : slot_count_q;
	assign batch_base = need_flush ? 15'd0 : batch_q;
	assign slot_sel   = !tex ? '0 : (found ? CNT_W'(enc) : cnt_base);

	// only draws and end scene need a queue entry
	assign dec_go = (state_q == F_DEC) && !q_full;
	assign push   = dec_go && (cmd_q == CMD_DRAW || cmd_q == CMD_END);

	always_comb begin
		push_job           = '0;
		push_job.is_end    = (cmd_q == CMD_END);
		push_job.pre_flush = (cmd_q == CMD_DRAW) && need_flush;
		push_job.fcount    = batch_q;
		push_job.pos_x     = pos_x_q;
		push_job.pos_y     = pos_y_q;
		push_job.pos_z     = pos_z_q;
		push_job.size_x    = size_x_q;
		push_job.size_y    = size_y_q;
		push_job.angle     = angle_q;
		push_job.slot      = slot_sel[4:0];
		push_job.tiling    = tex ? tiling_q : 16'd256;
		push_job.color     = color_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && cmd_valid) begin
			cmd_q    <= cmd;
			pos_x_q  <= pos_x;
			pos_y_q  <= pos_y;
			pos_z_q  <= pos_z;
			size_x_q <= size_x;
			size_y_q <= size_y;
			angle_q  <= angle;
			tid_q    <= texture_id;
			tiling_q <= tiling;
			color_q  <= color;
		end
		if (state_q == F_CMP)
			for (int i = 1; i < SLOT_TABLE_SIZE; i++)
				match_q[i] <= (slot_ids_q[i] == tid_q) && (32'(i) < 32'(slot_count_q));
		if (dec_go && cmd_q == CMD_DRAW && tex && !found &&
			32'(cnt_base) < 32'(SLOT_TABLE_SIZE))
			slot_ids_q[cnt_base[SIDX_W-1:0]] <= tid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			slot_count_q <= CNT_W'(1);
			batch_q      <= 15'd0;
		end else begin
			case (state_q)
				F_IDLE: if (cmd_valid) state_q <= F_CMP;
				F_CMP:  state_q <= F_DEC;
				F_DEC: begin
					if (dec_go) begin
						state_q <= F_IDLE;
						if (cmd_q == CMD_BEGIN) begin
							slot_count_q <= CNT_W'(1);
							batch_q      <= 15'd0;
						end else if (cmd_q == CMD_DRAW) begin
							batch_q <= batch_base + 15'd1;
							if (tex && !found)
								slot_count_q <= cnt_base + CNT_W'(1);
							else
								slot_count_q <= cnt_base;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/sqbs_queue.sv
// Short job queue between the front end and the vertex back end.
// Depends on sqbs_pkg for the job type and depth.
module sqbs_queue import sqbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sqbs_job_t push_job,
	output logic      full,
	input  logic      pop,
	output sqbs_job_t pop_job,
	output logic      empty
);

	sqbs_job_t         mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full    = (32'(cnt_q) == 32'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk)
		if (push && !full)
			mem_q[wr_q] <= push_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (32'(wr_q) == QDEPTH - 1) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (32'(rd_q) == QDEPTH - 1) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
		end
	end

endmodule

// File: rtl/core/sqbs_back.sv
// Vertex back end: sine lookup, corner products, flush markers and output register.
// Depends on sqbs_pkg; pops jobs from sqbs_queue.
module sqbs_back import sqbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  sqbs_job_t        q_job,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             kind,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic signed [31:0] vert_z,
	output logic             tex_u,
	output logic             tex_v,
	output logic [4:0]       slot,
	output logic [15:0]      tiling_out,
	output logic [31:0]      color_out,
	output logic [14:0]      batch_count,
	output logic             last
);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_FLUSH = 3'd1;
	localparam logic [2:0] B_SIN   = 3'd2;
	localparam logic [2:0] B_MUL   = 3'd3;
	localparam logic [2:0] B_CORN  = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          k_q;
	sqbs_job_t           job_q;
	logic [15:0]         sin_q, cos_q;
	logic signed [47:0]  a_q, b_q, c_q, d_q;
	logic                out_free;
	logic                emit;

	logic [15:0]         cos_ang;
	logic signed [15:0]  sin_v, cos_v;
	logic                cu, cv;
	logic signed [48:0]  rx, ry;
	logic signed [50:0]  sum_x, sum_y;
	logic signed [35:0]  fl_x, fl_y;
	logic signed [31:0]  sat_x, sat_y;

	// table index of the quarter wave, mirrored in odd quadrants
	function automatic logic [SIN_W-1:0] sine_idx(input logic [15:0] a);
		logic [SIN_W+13:0] prod;
		logic [SIN_W-1:0]  idx;
		prod = (SIN_W+14)'(a[13:0]) * (SIN_W+14)'(SINE_ENTRIES);
		idx  = prod[SIN_W+13:14];
		if (a[14])
			idx = SIN_W'(SINE_ENTRIES) - idx;
		return idx;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -36'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	assign out_free = !res_valid || !res_stall;
	assign emit     = ((state_q == B_FLUSH) || (state_q == B_CORN)) && out_free;
	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign cos_ang  = job_q.angle + 16'd16384;
	// negate the table value in the lower half wave
	assign sin_v    = job_q.angle[15] ? -$signed(sin_q) : $signed(sin_q);
	assign cos_v    = cos_ang[15] ? -$signed(cos_q) : $signed(cos_q);

	// corner order: (-,-) (+,-) (+,+) (-,+)
	assign cu    = (k_q == 2'd1) || (k_q == 2'd2);
	assign cv    = k_q[1];
	assign rx    = (cu ? 49'(a_q) : -49'(a_q)) - (cv ? 49'(b_q) : -49'(b_q));
	assign ry    = (cu ? 49'(c_q) : -49'(c_q)) + (cv ? 49'(d_q) : -49'(d_q));
	assign sum_x = ($signed(51'($signed(job_q.pos_x))) <<< 15) + 51'(rx) + 51'sd16384;
	assign sum_y = ($signed(51'($signed(job_q.pos_y))) <<< 15) + 51'(ry) + 51'sd16384;
	assign fl_x  = sum_x[50:15];
	assign fl_y  = sum_y[50:15];
	assign sat_x = sat32(fl_x);
	assign sat_y = sat32(fl_y);

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= q_job;
		if (state_q == B_SIN) begin
			sin_q <= SINE_TAB[sine_idx(job_q.angle)];
			cos_q <= SINE_TAB[sine_idx(cos_ang)];
		end
		if (state_q == B_MUL) begin
			a_q <= cos_v * $signed(job_q.size_x);
			b_q <= sin_v * $signed(job_q.size_y);
			c_q <= sin_v * $signed(job_q.size_x);
			d_q <= cos_v * $signed(job_q.size_y);
		end
		if (state_q == B_FLUSH && out_free) begin
			kind        <= KIND_FLUSH;
			vert_x      <= '0;
			vert_y      <= '0;
			vert_z      <= '0;
			tex_u       <= 1'b0;
			tex_v       <= 1'b0;
			slot        <= '0;
			tiling_out  <= '0;
			color_out   <= '0;
			batch_count <= job_q.fcount;
			last        <= job_q.is_end;
		end
		if (state_q == B_CORN && out_free) begin
			kind        <= KIND_VERTEX;
			vert_x      <= sat_x;
			vert_y      <= sat_y;
			vert_z      <= job_q.pos_z;
			tex_u       <= cu;
			tex_v       <= cv;
			slot        <= job_q.slot;
			tiling_out  <= job_q.tiling;
			color_out   <= job_q.color;
			batch_count <= '0;
			last        <= (k_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			k_q       <= '0;
			res_valid <= 1'b0;
		end else begin
			if (emit)
				res_valid <= 1'b1;
			else if (!res_stall)
				res_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty)
						state_q <= (q_job.is_end || q_job.pre_flush) ? B_FLUSH : B_SIN;
				end
				B_FLUSH: begin
					if (out_free)
						state_q <= job_q.is_end ? B_IDLE : B_SIN;
				end
				B_SIN: state_q <= B_MUL;
				B_MUL: begin
					state_q <= B_CORN;
					k_q     <= '0;
				end
				B_CORN: begin
					if (out_free) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3)
							state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/sprite_quad_batch_setup_unit.sv
// Path: an accepted draw request passes the front end compare and decide states, the job
// queue, then the back end flush state when a marker is due, the sine read, product and corner states.
// Throughput is set by the back end sequencer (sine read, product stage, then one vertex per
// cycle into the output register while the result port does not stall); the front end
// takes a new request only from its idle state and a two-entry queue decouples the two.
// Reset: arst_n clears the batch to empty and the slot table to the white slot only.
// Top level: front end, job queue and vertex back end; depends on sqbs_pkg.
module sprite_quad_batch_setup_unit import sqbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] size_x,
	input  logic signed [31:0] size_y,
	input  logic [15:0]        angle,
	input  logic [15:0]        texture_id,
	input  logic [15:0]        tiling,
	input  logic [31:0]        color,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               kind,
	output logic signed [31:0] vert_x,
	output logic signed [31:0] vert_y,
	output logic signed [31:0] vert_z,
	output logic               tex_u,
	output logic               tex_v,
	output logic [4:0]         slot,
	output logic [15:0]        tiling_out,
	output logic [31:0]        color_out,
	output logic [14:0]        batch_count,
	output logic               last
);

	logic      push, q_full, pop, q_empty;
	sqbs_job_t push_job, pop_job;

	sqbs_front u_front (
		.clk, .arst_n, .cmd_valid, .cmd_stall, .cmd,
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.size_x(size_x), .size_y(size_y), .angle, .texture_id, .tiling, .color,
		.push, .push_job, .q_full
	);

	sqbs_queue u_queue (
		.clk, .arst_n, .push, .push_job, .full(q_full),
		.pop, .pop_job, .empty(q_empty)
	);

	sqbs_back u_back (
		.clk, .arst_n, .q_empty, .q_job(pop_job), .pop,
		.res_valid, .res_stall, .kind, .vert_x, .vert_y, .vert_z,
		.tex_u, .tex_v, .slot, .tiling_out, .color_out, .batch_count, .last
	);

endmodule

// File: rtl/core/sqbs_checker.sv
// Port-level checks on the result channel of the sprite quad setup unit.
// Depends on sqbs_pkg; bound to sprite_quad_batch_setup_unit below.
module sqbs_port_props import sqbs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic        kind,
	input logic [31:0] vert_x,
	input logic [31:0] vert_z,
	input logic        tex_u,
	input logic        tex_v,
	input logic [4:0]  slot,
	input logic [14:0] batch_count,
	input logic        last
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(vert_x) && $stable(kind))
		else $error("stalled result changed");

	a_flush_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_FLUSH |->
			vert_x == '0 && vert_z == '0 && !tex_u && !tex_v && slot == '0)
		else $error("flush marker carries vertex data");

	a_vert_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_VERTEX |-> batch_count == '0)
		else $error("vertex carries batch count");

	// the fourth corner closes the quad
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_VERTEX |-> last == (tex_v && !tex_u))
		else $error("last flag on wrong corner");

endmodule

bind sprite_quad_batch_setup_unit sqbs_port_props u_sqbs_port_props (
	.clk, .arst_n, .res_valid, .res_stall, .kind, .vert_x, .vert_z,
	.tex_u, .tex_v, .slot, .batch_count, .last
);
